/* hdl/lqric_pkg.sv */
// Shared types, gain tables and saturation helpers for the LQR integral controller.
// No dependencies; used by every module under hdl/.
package lqric_pkg;

  localparam int unsigned LANES   = 4;
  localparam int unsigned STATES  = 8;
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned INTEG_W = 48;

  // Shared multiplier of one lane: 33-bit by 26-bit signed
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 26;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W   = PROD_W + 2;
  localparam int unsigned INC_W   = 33;
  localparam int unsigned Y_W     = PROD_W + 1;

  localparam logic [DT_W-1:0] DT_RESET = 16'd655;

  // Each drive row has exactly two nonzero state gains
  localparam logic [2:0] COL_A [LANES] = '{3'd0, 3'd2, 3'd3, 3'd4};
  localparam logic [2:0] COL_B [LANES] = '{3'd1, 3'd5, 3'd6, 3'd7};
  localparam logic signed [MUL_B_W-1:0] GAIN_A [LANES] =
    '{-26'sd17386544, 26'sd169810, 26'sd170433, 26'sd144166};
  localparam logic signed [MUL_B_W-1:0] GAIN_B [LANES] =
    '{-26'sd3402249, 26'sd22964, 26'sd23377, 26'sd24602};
  localparam logic signed [MUL_B_W-1:0] GAIN_I [LANES] =
    '{-26'sd6553600, 26'sd253821, 26'sd253821, 26'sd160530};

  typedef logic [STATES-1:0][FIELD_W-1:0] state_vec_t;

  // Lane sequence steps
  typedef enum logic [2:0] {
    STEP_MUL_DT,
    STEP_MUL_XA,
    STEP_MUL_XB,
    STEP_MUL_LO,
    STEP_MUL_HI,
    STEP_DRIVE,
    STEP_DONE
  } step_t;

  typedef struct packed {
    logic  load;
    logic  run;
    step_t step;
  } lqric_ctrl_t;

  // Clamp a 49-bit sum to the 48-bit signed range
  function automatic logic [INTEG_W-1:0] sat48(input logic [INTEG_W:0] v);
    logic [INTEG_W-1:0] r;
    if (v[INTEG_W] == v[INTEG_W-1]) begin
      r = v[INTEG_W-1:0];
    end else if (v[INTEG_W]) begin
      r = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(INTEG_W-1){1'b1}}};
    end
    return r;
  endfunction

  // Clamp a wide drive value to 32-bit signed
  function automatic logic [FIELD_W-1:0] sat32(input logic [Y_W-1:0] v);
    logic [FIELD_W-1:0] r;
    if (v[Y_W-1:FIELD_W-1] == {(Y_W-FIELD_W+1){1'b0}} ||
        v[Y_W-1:FIELD_W-1] == {(Y_W-FIELD_W+1){1'b1}}) begin
      r = v[FIELD_W-1:0];
    end else if (v[Y_W-1]) begin
      r = {1'b1, {(FIELD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(FIELD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* hdl/lqric_lane.sv */
// One controller lane: trapezoidal integrator and one drive row, five products
// through a single shared multiplier. Depends on lqric_pkg.
module lqric_lane
  import lqric_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  lqric_ctrl_t         ctrl,
  input  logic [DT_W-1:0]     sample_period,
  input  state_vec_t          x_vec,
  input  logic [FIELD_W-1:0]  err,
  output logic [FIELD_W-1:0]  drive
);

  logic signed [FIELD_W-1:0] prev_err;
  logic signed [INTEG_W-1:0] integ;
  logic signed [MUL_A_W-1:0] err_sum;
  logic signed [FIELD_W-1:0] xa;
  logic signed [FIELD_W-1:0] xb;
  logic signed [PROD_W-1:0]  prod;
  logic signed [INC_W-1:0]   inc;
  logic signed [ACC_W-1:0]   acc;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic        [INTEG_W:0]   integ_sum;
  logic signed [Y_W-1:0]     y;

  // Operand select for the shared multiplier
  always_comb begin
    case (ctrl.step)
      STEP_MUL_DT: begin
        mul_a = err_sum;
        mul_b = $signed({{(MUL_B_W-DT_W){1'b0}}, sample_period});
      end
      STEP_MUL_XA: begin
        mul_a = MUL_A_W'(xa);
        mul_b = GAIN_A[LANE];
      end
      STEP_MUL_XB: begin
        mul_a = MUL_A_W'(xb);
        mul_b = GAIN_B[LANE];
      end
      STEP_MUL_LO: begin
        mul_a = $signed({{(MUL_A_W-16){1'b0}}, integ[15:0]});
        mul_b = GAIN_I[LANE];
      end
      STEP_MUL_HI: begin
        mul_a = MUL_A_W'($signed(integ[INTEG_W-1:16]));
        mul_b = GAIN_I[LANE];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Integrator increment, rounded half up; product fits 50 bits
  assign prod_rnd  = prod + PROD_W'(65536);
  assign integ_sum = {integ[INTEG_W-1], integ} + {{(INTEG_W-INC_W+1){inc[INC_W-1]}}, inc};

  // Drive: high integral product plus rounded accumulator
  assign y = Y_W'(prod) + Y_W'(acc >>> 16);

  // Persistent lane state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      if (ctrl.load) begin
        prev_err <= err;
      end
      if (ctrl.run && ctrl.step == STEP_MUL_XB) begin
        integ <= sat48(integ_sum);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      err_sum <= MUL_A_W'(prev_err) + MUL_A_W'($signed(err));
      xa      <= x_vec[COL_A[LANE]];
      xb      <= x_vec[COL_B[LANE]];
    end
    if (ctrl.run) begin
      prod <= mul_p;
      case (ctrl.step)
        STEP_MUL_XA: inc   <= prod_rnd[49:17];
        STEP_MUL_XB: acc   <= ACC_W'(prod);
        STEP_MUL_LO: acc   <= acc + ACC_W'(prod);
        STEP_MUL_HI: acc   <= acc + ACC_W'(prod) + ACC_W'(32768);
        STEP_DRIVE:  drive <= sat32(y);
        default: ;
      endcase
    end
  end

endmodule

/* hdl/lqric_merge.sv */
// Merge stage: gathers the four lane drives into one output request register.
// Depends on lqric_pkg.
module lqric_merge
  import lqric_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [LANES-1:0][FIELD_W-1:0] lane_drive,
  input  logic                      out_stall,
  output logic                      free,
  output logic                      out_valid,
  output logic [FIELD_W-1:0]        drive_thrust,
  output logic [FIELD_W-1:0]        drive_roll,
  output logic [FIELD_W-1:0]        drive_pitch,
  output logic [FIELD_W-1:0]        drive_yaw
);

  assign free = !out_valid || !out_stall;

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload, held while stalled
  always_ff @(posedge clk) begin
    if (load) begin
      drive_thrust <= lane_drive[0];
      drive_roll   <= lane_drive[1];
      drive_pitch  <= lane_drive[2];
      drive_yaw    <= lane_drive[3];
    end
  end

endmodule

/* hdl/lqr_integral_controller_unit.sv */
// Top level of the LQR controller with integral action: sequencer, sample
// period register, four lanes and the merge stage. Depends on lqric_pkg.
//
//  channel  handshake            direction  payload
//  in       in_valid / in_stall  input      eight states, four errors
//  out      out_valid/out_stall  output     four drives
//  cfg      cfg_valid/cfg_ready  input      sample_period (cfg_data)
//
// Each item is accepted, then runs through seven sequencer steps in which each
// lane runs its five products through its single multiplier and saturates.
// A finished result sits in the merge register, so the next request is taken
// while it waits; the sequencer only holds if that register is full and stalled.
// Reset (rst, synchronous) clears integrators, previous errors, sample_period
// to 655 and all handshake state. cfg_ready is always high.
module lqr_integral_controller_unit
  import lqric_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        altitude,
  input  logic [31:0]        vertical_speed,
  input  logic [31:0]        roll_angle,
  input  logic [31:0]        pitch_angle,
  input  logic [31:0]        yaw_angle,
  input  logic [31:0]        roll_speed,
  input  logic [31:0]        pitch_speed,
  input  logic [31:0]        yaw_speed,
  input  logic [31:0]        err_altitude,
  input  logic [31:0]        err_roll,
  input  logic [31:0]        err_pitch,
  input  logic [31:0]        err_yaw,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        drive_thrust,
  output logic [31:0]        drive_roll,
  output logic [31:0]        drive_pitch,
  output logic [31:0]        drive_yaw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic                          busy;
  step_t                         step;
  step_t                         step_next;
  logic [DT_W-1:0]               sample_period;
  lqric_ctrl_t                   ctrl;
  logic                          out_free;
  logic                          load_out;
  state_vec_t                    x_vec;
  logic [LANES-1:0][FIELD_W-1:0] errs;
  logic [LANES-1:0][FIELD_W-1:0] lane_drive;

  assign cfg_ready = 1'b1;
  assign in_stall  = busy;

  assign x_vec = {yaw_speed, pitch_speed, roll_speed, yaw_angle,
                  pitch_angle, roll_angle, vertical_speed, altitude};
  assign errs  = {err_yaw, err_pitch, err_roll, err_altitude};

  assign ctrl.load = in_valid && !busy;
  assign ctrl.run  = busy;
  assign ctrl.step = step;
  assign load_out  = busy && step == STEP_DONE && out_free;

  // Step sequence
  always_comb begin
    case (step)
      STEP_MUL_DT: step_next = STEP_MUL_XA;
      STEP_MUL_XA: step_next = STEP_MUL_XB;
      STEP_MUL_XB: step_next = STEP_MUL_LO;
      STEP_MUL_LO: step_next = STEP_MUL_HI;
      STEP_MUL_HI: step_next = STEP_DRIVE;
      STEP_DRIVE:  step_next = STEP_DONE;
      default:     step_next = STEP_DONE;
    endcase
  end

  // Sequencer and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      step          <= STEP_MUL_DT;
      sample_period <= DT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_period <= cfg_data;
      end
      if (ctrl.load) begin
        busy <= 1'b1;
        step <= STEP_MUL_DT;
      end else if (busy) begin
        if (step == STEP_DONE) begin
          if (out_free) begin
            busy <= 1'b0;
          end
        end else begin
          step <= step_next;
        end
      end
    end
  end

  // Lanes, one per drive row
  for (genvar r = 0; r < LANES; r++) begin : g_lane
    lqric_lane #(.LANE(r)) u_lane (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .sample_period (sample_period),
      .x_vec         (x_vec),
      .err           (errs[r]),
      .drive         (lane_drive[r])
    );
  end

  lqric_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (load_out),
    .lane_drive   (lane_drive),
    .out_stall    (out_stall),
    .free         (out_free),
    .out_valid    (out_valid),
    .drive_thrust (drive_thrust),
    .drive_roll   (drive_roll),
    .drive_pitch  (drive_pitch),
    .drive_yaw    (drive_yaw)
  );

  // An accepted request starts the sequence at its first step
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> busy && step == STEP_MUL_DT)
    else $error("sequence did not start on accept");

  // A new output only appears after a completed sequence
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy) && $past(step) == STEP_DONE)
    else $error("output raised without finished sequence");

  // The sequencer releases only by handing a result to the merge stage
  a_release: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(load_out))
    else $error("sequencer released without delivering");

endmodule

/* bench/lqric_checker.sv */
// Checker for the LQR integral controller: watches the request, drive and
// sample-period channels, predicts every drive set and compares it on arrival.
// Depends on lqric_pkg for widths and the sample-period reset value.
module lqric_checker
  import lqric_pkg::*;
(
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [STATES-1:0][FIELD_W-1:0] meas,
  input  logic [LANES-1:0][FIELD_W-1:0]  trk_err,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [LANES-1:0][FIELD_W-1:0]  drive,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [DT_W-1:0]                cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [LANES-1:0][FIELD_W-1:0] drive_set_t;

  // Full-state gains and integral gains, Q.16
  localparam longint STATE_GAIN [LANES][STATES] = '{
    '{-17386544, -3402249, 0, 0, 0, 0, 0, 0},
    '{0, 0, 169810, 0, 0, 22964, 0, 0},
    '{0, 0, 0, 170433, 0, 0, 23377, 0},
    '{0, 0, 0, 0, 144166, 0, 0, 24602}
  };
  localparam longint INTEG_GAIN [LANES] = '{-6553600, 253821, 253821, 160530};
  localparam longint INTEG_MAX = 64'sd140737488355327;
  localparam longint INTEG_MIN = -INTEG_MAX - 1;

  logic [DT_W-1:0] period;
  longint          integ    [LANES];
  longint          prev_err [LANES];
  drive_set_t      drive_queue [$];

  function automatic string lane_name(input int r);
    case (r)
      0:       return "drive_thrust";
      1:       return "drive_roll";
      2:       return "drive_pitch";
      default: return "drive_yaw";
    endcase
  endfunction

  // Advance the trapezoidal integrators, then form the four drives
  function automatic drive_set_t predict_drives(
    input logic [STATES-1:0][FIELD_W-1:0] x_in,
    input logic [LANES-1:0][FIELD_W-1:0]  e_in
  );
    drive_set_t        res;
    longint            e;
    longint            step;
    longint            acc;
    logic signed [95:0] wide;
    for (int r = 0; r < LANES; r++) begin
      e = $signed(e_in[r]);
      // round half up on the 2^17 divide
      step = ((prev_err[r] + e) * longint'(period) + 64'sd65536) >>> 17;
      integ[r] = integ[r] + step;
      if (integ[r] > INTEG_MAX) integ[r] = INTEG_MAX;
      if (integ[r] < INTEG_MIN) integ[r] = INTEG_MIN;
      prev_err[r] = e;
    end
    for (int r = 0; r < LANES; r++) begin
      acc = 0;
      for (int c = 0; c < STATES; c++) begin
        acc += STATE_GAIN[r][c] * longint'($signed(x_in[c]));
      end
      // all operands signed, so they widen to 96 bits before the multiply
      wide = acc + INTEG_GAIN[r] * integ[r] + 32768;
      wide = wide >>> 16;
      if (wide > 96'sd2147483647) wide = 96'sd2147483647;
      if (wide < -96'sd2147483648) wide = -96'sd2147483648;
      res[r] = wide[FIELD_W-1:0];
    end
    return res;
  endfunction

  // Track requests and compare drive sets in arrival order
  always @(posedge clk) begin
    drive_set_t want;
    if (rst) begin
      mismatches = 0;
      period = DT_RESET;
      for (int r = 0; r < LANES; r++) begin
        integ[r]    = 0;
        prev_err[r] = 0;
      end
      drive_queue.delete();
    end else begin
      if (cfg_valid && cfg_ready) period = cfg_data;
      if (in_valid && !in_stall) drive_queue.push_back(predict_drives(meas, trk_err));
      if (out_valid && !out_stall) begin
        if (drive_queue.size() == 0) begin
          mismatches++;
          $error("drive set arrived with no request pending");
        end else begin
          want = drive_queue.pop_front();
          for (int r = 0; r < LANES; r++) begin
            if (drive[r] !== want[r]) begin
              mismatches++;
              $error("%s: expected %0d, got %0d", lane_name(r),
                     $signed(want[r]), $signed(drive[r]));
            end
          end
        end
      end
    end
    outstanding = drive_queue.size();
  end

endmodule

/* bench/tb_top.sv */
// Testbench top for the LQR integral controller: clock, reset, request and
// sample-period stimulus, random stalls and the verdict.
// Depends on lqric_pkg, lqr_integral_controller_unit and lqric_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lqric_pkg::*;

  typedef logic [LANES-1:0][FIELD_W-1:0] err_vec_t;

  localparam logic [FIELD_W-1:0] MAXV = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] MINV = 32'h8000_0000;
  localparam int PHASE_ITEMS = 160;
  localparam int SWEEP_ITEMS = 60;

  logic            clk;
  logic            rst;
  logic            in_valid;
  logic            out_stall;
  logic            cfg_valid;
  logic [DT_W-1:0] cfg_data;
  state_vec_t      meas;
  err_vec_t        trk_err;
  err_vec_t        last_err;
  wire             in_stall;
  wire             out_valid;
  wire             cfg_ready;
  wire  [LANES-1:0][FIELD_W-1:0] drive;
  int              mismatches;
  int              outstanding;
  bit              quiet;

  lqr_integral_controller_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .altitude       (meas[0]),
    .vertical_speed (meas[1]),
    .roll_angle     (meas[2]),
    .pitch_angle    (meas[3]),
    .yaw_angle      (meas[4]),
    .roll_speed     (meas[5]),
    .pitch_speed    (meas[6]),
    .yaw_speed      (meas[7]),
    .err_altitude   (trk_err[0]),
    .err_roll       (trk_err[1]),
    .err_pitch      (trk_err[2]),
    .err_yaw        (trk_err[3]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .drive_thrust   (drive[0]),
    .drive_roll     (drive[1]),
    .drive_pitch    (drive[2]),
    .drive_yaw      (drive[3]),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  lqric_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .meas        (meas),
    .trk_err     (trk_err),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .drive       (drive),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Random back-pressure on drive sets, off during quiet stretches
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= !quiet && ($urandom_range(99) < 38);
    end
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Random field: mostly sign-extended values of random size, some corners
  function automatic logic [FIELD_W-1:0] rand_field();
    int unsigned      bits;
    logic [FIELD_W-1:0] v;
    v = $urandom();
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(6))
        0:       v = MAXV;
        1:       v = MINV;
        2:       v = '0;
        3:       v = 32'h0000_0001;
        4:       v = 32'hFFFF_FFFF;
        5:       v = 32'h0001_0000;
        default: v = 32'hFFFF_0000;
      endcase
    end else begin
      bits = $urandom_range(1, FIELD_W);
      v = $signed(v << (FIELD_W - bits)) >>> (FIELD_W - bits);
    end
    return v;
  endfunction

  // Drive one request and hold it until accepted
  task automatic push_request(input state_vec_t x, input err_vec_t e);
    while (!quiet && $urandom_range(99) < 38) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    meas     <= x;
    trk_err  <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    last_err = e;
  endtask

  // Let every pending drive set come out, then give the block time to go idle
  task automatic drain_requests();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic write_period(input logic [DT_W-1:0] dt);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dt;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    state_vec_t      x;
    err_vec_t        e;
    logic [DT_W-1:0] dt;
    rst       = 1'b1;
    in_valid  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    meas      = '0;
    trk_err   = '0;
    last_err  = '0;
    quiet     = 1'b0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset period: drive rounding ties on the roll row, extremes
    push_request({STATES{32'h0000_4000}}, '0);
    push_request({STATES{32'hFFFF_C000}}, '0);
    push_request('0, '0);
    push_request({STATES{MAXV}}, {LANES{MAXV}});
    push_request({STATES{MAXV}}, {LANES{MAXV}});
    push_request({STATES{MINV}}, {LANES{MINV}});
    push_request({STATES{MINV}}, {LANES{MINV}});
    push_request({(STATES/2){MAXV, MINV}}, {(LANES/2){MINV, MAXV}});
    push_request({(STATES/2){32'h0000_0001, 32'hFFFF_FFFF}}, {LANES{32'hFFFF_FFFF}});

    // Smallest nonzero period: integrator ties, up and down
    drain_requests();
    write_period(16'd1);
    push_request('0, '0);
    push_request('0, {LANES{32'h0001_0000}});
    push_request('0, {LANES{32'hFFFE_0000}});

    // Zero period holds the integrators
    drain_requests();
    write_period(16'd0);
    push_request({STATES{MAXV}}, {LANES{MAXV}});
    push_request({STATES{MINV}}, {LANES{MINV}});

    // Largest period
    drain_requests();
    write_period(16'hFFFF);
    push_request({STATES{MAXV}}, {LANES{MAXV}});
    push_request({STATES{MINV}}, {LANES{MINV}});
    push_request({STATES{32'h0001_0000}}, {LANES{MAXV}});

    // Random phases, one period each; errors often cancel the previous ones
    // so the integrators wander instead of pinning every drive
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       dt = 16'hFFFF;
        1:       dt = 16'($urandom());
        2:       dt = 16'd0;
        3:       dt = 16'($urandom_range(1, 2000));
        4:       dt = 16'd1;
        default: dt = 16'($urandom());
      endcase
      drain_requests();
      write_period(dt);
      quiet = (ph == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        for (int c = 0; c < STATES; c++) x[c] = rand_field();
        for (int r = 0; r < LANES; r++)
          e[r] = ($urandom_range(99) < 40) ? -last_err[r] : rand_field();
        push_request(x, e);
      end
    end
    quiet = 1'b0;

    // Steady full positive error at the largest period drives the
    // integrators up, then a few pulls back down
    drain_requests();
    write_period(16'hFFFF);
    quiet = 1'b1;
    for (int n = 0; n < SWEEP_ITEMS; n++) begin
      for (int c = 0; c < STATES; c++) x[c] = rand_field();
      push_request(x, {LANES{MAXV}});
    end
    for (int n = 0; n < 4; n++) push_request('0, {LANES{MINV}});
    quiet = 1'b0;

    drain_requests();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
